// File: design/lsdrs_pkg.sv
// Package with the shared types, constants and helpers of the decimal radix sorter.
`timescale 1ns / 1ps
package lsdrs_pkg;

  // Port widths of the stream payloads.
  localparam int KEY_W      = 16;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  // Defaults of the top-level parameters.
  localparam int DEF_MAX_KEYS = 64;
  localparam int DEF_KEY_BITS = 16;

  // Decimal radix and the reciprocal used to divide a 16-bit value by ten.
  localparam int RADIX       = 10;
  localparam int DIGIT_W     = 4;
  localparam int DIV10_MUL   = 52429;
  localparam int DIV10_SHIFT = 19;

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_PASS,
    S_HIST,
    S_PREFIX,
    S_PLACE,
    S_OUT_RD,
    S_OUT_LD
  } sort_state_t;

  // Exact quotient by ten for every 16-bit value: one multiply and a shift.
  function automatic logic [KEY_W-1:0] div10(input logic [KEY_W-1:0] q);
    logic [KEY_W+16:0] prod;
    prod = {17'd0, q} * (KEY_W + 17)'(DIV10_MUL);
    return KEY_W'(prod >> DIV10_SHIFT);
  endfunction

endpackage

// File: design/lsd_decimal_radix_sort.sv
// Top level of the LSD decimal radix sorter: key store, pass memories and sequencer.
`timescale 1ns / 1ps
// Keys are loaded one per cycle until a transfer with tlast set; keys beyond MAX_KEYS are
// discarded and every result of that set carries tuser high. The set is then sorted by
// stable decimal counting passes, one pass per decimal digit of the largest key (at most
// five for 16-bit keys). All passes run against two ping-pong memories with one read port
// each, so a pass reads every stored key once for the histogram, forms the prefix sum over
// the ten digit counts and reads every key once more for placement. The results then leave
// one key at a time, each fetched by the registered memory read before it is loaded into
// the output register, which holds while out_tready is low; the next set may start loading
// as soon as the last result sits in the output register.
module lsd_decimal_radix_sort #(
  parameter int MAX_KEYS = lsdrs_pkg::DEF_MAX_KEYS,
  parameter int KEY_BITS = lsdrs_pkg::DEF_KEY_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lsdrs_pkg::IN_DATA_W-1:0]  in_tdata,   // [15:0] key
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lsdrs_pkg::OUT_DATA_W-1:0] out_tdata,  // [15:0] sorted_key
  output logic                             out_tlast,
  output logic                             out_tuser   // [0] dropped
);
  import lsdrs_pkg::*;

  // Only the low KEY_BITS of the 16-bit key take part.
  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int MW = 2 * KW;
  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = $clog2(MAX_KEYS + 1);

  // Each entry holds the key and its quotient by the current place value.
  logic [MW-1:0] mem0 [MAX_KEYS];
  logic [MW-1:0] mem1 [MAX_KEYS];
  logic [MW-1:0] rd0_r, rd1_r;

  logic          re;
  logic [AW-1:0] ra;
  logic          we0, we1;
  logic [AW-1:0] wa0, wa1;
  logic [MW-1:0] wd0, wd1;

  sort_state_t   state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [KW-1:0] max_r, max_nxt;
  logic [KW-1:0] lq_r, lq_nxt;
  logic          ovf_r, ovf_nxt;
  logic          src_r, src_nxt;
  logic          rv_r, rv_nxt;
  digit_t        pidx_r, pidx_nxt;
  logic [CW-1:0] counts_r [RADIX];
  logic [CW-1:0] counts_nxt [RADIX];

  logic                  out_valid_r, out_valid_nxt;
  logic [KW-1:0]         out_key_r, out_key_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_drop_r, out_drop_nxt;

  logic [KW-1:0] in_key;
  logic [MW-1:0] d_word;
  logic [KW-1:0] d_key, d_q, d_quo, lq_quo;
  digit_t        d_dig;
  logic [CW-1:0] idx_dec, last_idx, pos;

  assign in_key   = in_tdata[KW-1:0];
  assign d_word   = src_r ? rd1_r : rd0_r;
  assign d_key    = d_word[MW-1:KW];
  assign d_q      = d_word[KW-1:0];
  assign d_quo    = KW'(div10(KEY_W'(d_q)));
  assign d_dig    = DIGIT_W'(d_q - KW'((d_quo << 3) + (d_quo << 1)));
  assign lq_quo   = KW'(div10(KEY_W'(lq_r)));
  assign idx_dec  = idx_r - 1'b1;
  assign last_idx = cnt_r - 1'b1;
  assign pos      = counts_r[d_dig] - 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_key_r);
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_drop_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    max_nxt       = max_r;
    lq_nxt        = lq_r;
    ovf_nxt       = ovf_r;
    src_nxt       = src_r;
    rv_nxt        = 1'b0;
    pidx_nxt      = pidx_r;
    counts_nxt    = counts_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_key_nxt   = out_key_r;
    out_last_nxt  = out_last_r;
    out_drop_nxt  = out_drop_r;
    in_tready     = 1'b0;
    re            = 1'b0;
    ra            = idx_r[AW-1:0];
    we0           = 1'b0;
    wa0           = cnt_r[AW-1:0];
    wd0           = {in_key, in_key};
    we1           = 1'b0;
    wa1           = pos[AW-1:0];
    wd1           = {d_key, d_quo};

    case (state_r)
      S_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (cnt_r < CW'(MAX_KEYS)) begin
            we0     = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
            if (in_key > max_r) begin
              max_nxt = in_key;
            end
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            lq_nxt    = max_nxt;
            state_nxt = S_PASS;
          end
        end
      end
      S_PASS: begin
        idx_nxt = '0;
        for (int d = 0; d < RADIX; d++) begin
          counts_nxt[d] = '0;
        end
        state_nxt = (lq_r == '0) ? S_OUT_RD : S_HIST;
      end
      S_HIST: begin
        if (idx_r < cnt_r) begin
          re      = 1'b1;
          idx_nxt = idx_r + 1'b1;
          rv_nxt  = 1'b1;
        end else if (!rv_r) begin
          pidx_nxt  = digit_t'(1);
          state_nxt = S_PREFIX;
        end
        if (rv_r) begin
          counts_nxt[d_dig] = counts_r[d_dig] + 1'b1;
        end
      end
      S_PREFIX: begin
        counts_nxt[pidx_r] = counts_r[pidx_r] + counts_r[pidx_r - 1'b1];
        if (pidx_r == digit_t'(RADIX - 1)) begin
          idx_nxt   = cnt_r;
          state_nxt = S_PLACE;
        end else begin
          pidx_nxt = pidx_r + 1'b1;
        end
      end
      S_PLACE: begin
        // Keys are read from the back so equal digits keep their order.
        if (idx_r != '0) begin
          re      = 1'b1;
          ra      = idx_dec[AW-1:0];
          idx_nxt = idx_dec;
          rv_nxt  = 1'b1;
        end else if (!rv_r) begin
          lq_nxt    = lq_quo;
          src_nxt   = !src_r;
          state_nxt = S_PASS;
        end
        if (rv_r) begin
          counts_nxt[d_dig] = pos;
          if (src_r) begin
            we0 = 1'b1;
            wa0 = pos[AW-1:0];
            wd0 = {d_key, d_quo};
          end else begin
            we1 = 1'b1;
          end
        end
      end
      S_OUT_RD: begin
        if (!out_valid_r || out_tready) begin
          re        = 1'b1;
          state_nxt = S_OUT_LD;
        end
      end
      S_OUT_LD: begin
        out_valid_nxt = 1'b1;
        out_key_nxt   = d_key;
        out_last_nxt  = (idx_r == last_idx);
        out_drop_nxt  = ovf_r;
        if (idx_r == last_idx) begin
          cnt_nxt   = '0;
          max_nxt   = '0;
          ovf_nxt   = 1'b0;
          src_nxt   = 1'b0;
          idx_nxt   = '0;
          state_nxt = S_LOAD;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_OUT_RD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      idx_r       <= '0;
      max_r       <= '0;
      lq_r        <= '0;
      ovf_r       <= 1'b0;
      src_r       <= 1'b0;
      rv_r        <= 1'b0;
      pidx_r      <= '0;
      out_valid_r <= 1'b0;
      for (int d = 0; d < RADIX; d++) begin
        counts_r[d] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      max_r       <= max_nxt;
      lq_r        <= lq_nxt;
      ovf_r       <= ovf_nxt;
      src_r       <= src_nxt;
      rv_r        <= rv_nxt;
      pidx_r      <= pidx_nxt;
      out_valid_r <= out_valid_nxt;
      counts_r    <= counts_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_key_r  <= out_key_nxt;
    out_last_r <= out_last_nxt;
    out_drop_r <= out_drop_nxt;
  end

  always_ff @(posedge clk) begin
    if (we0) begin
      mem0[wa0] <= wd0;
    end
    if (re) begin
      rd0_r <= mem0[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      mem1[wa1] <= wd1;
    end
    if (re) begin
      rd1_r <= mem1[ra];
    end
  end

endmodule
